@@ rtl/rts_pkg.sv @@
// Shared constants and types for the ring thread scheduler.
`timescale 1ns / 1ps

package rts_pkg;

  localparam int THREADS = 16;
  localparam int SLOT_W  = $clog2(THREADS);
  localparam int CNT_W   = $clog2(THREADS + 1);
  localparam int FLAG_W  = 5;

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [FLAG_W-1:0] flags_t;

  // flag bit positions
  localparam int F_FREE     = 0;
  localparam int F_RUNNING  = 1;
  localparam int F_RUNNABLE = 2;
  localparam int F_DETACHED = 3;
  localparam int F_JOINED   = 4;

  // operation codes
  localparam logic [2:0] OP_CREATE = 3'd0;
  localparam logic [2:0] OP_YIELD  = 3'd1;
  localparam logic [2:0] OP_EXIT   = 3'd2;
  localparam logic [2:0] OP_JOIN   = 3'd3;
  localparam logic [2:0] OP_WAKE   = 3'd4;

  // status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_IDLE    = 3'd1;
  localparam logic [2:0] ST_NOFREE  = 3'd2;
  localparam logic [2:0] ST_JOINDET = 3'd3;
  localparam logic [2:0] ST_DEFER   = 3'd4;
  localparam logic [2:0] ST_LAST    = 3'd5;

endpackage

@@ rtl/rts_ram.sv @@
// Generic single-write, single-read RAM with registered read data (read-first).
`timescale 1ns / 1ps

module rts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/ring_thread_scheduler.sv @@
// Round-robin thread slot manager: slot table, active ring and free list in RAMs.
//
//   channel | direction | beat contents
//   in      | input     | mode, detach, target
//   out     | output    | status, running, created, switched
//
// One operation at a time. Each step reads or writes the slot RAMs, whose
// read data is registered. Yield walks the ring; exit and join do so too
// unless they end early, and create and wake never do. The walk reads the
// next pointer of the start slot, then checks one slot at a time, up to
// THREADS visits. After reset a clearing pass over every slot initializes
// the RAMs; in_stall stays high meanwhile. A finished beat waits in the
// output register and the next input beat is taken while it does; that
// operation then holds in its last cycle until the register is free.
`timescale 1ns / 1ps

module ring_thread_scheduler (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_mode,
  input  logic               in_detach,
  input  logic [3:0]         in_target,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_status,
  output logic [3:0]         out_running,
  output logic [3:0]         out_created,
  output logic               out_switched
);

  import rts_pkg::*;

  localparam logic [4:0] S_INIT  = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_DISP  = 5'd2;
  localparam logic [4:0] S_CR1   = 5'd3;
  localparam logic [4:0] S_CR2   = 5'd4;
  localparam logic [4:0] S_EX1   = 5'd5;
  localparam logic [4:0] S_EX2   = 5'd6;
  localparam logic [4:0] S_EX3   = 5'd7;
  localparam logic [4:0] S_EX4   = 5'd8;
  localparam logic [4:0] S_JN1   = 5'd9;
  localparam logic [4:0] S_JN2   = 5'd10;
  localparam logic [4:0] S_JN3   = 5'd11;
  localparam logic [4:0] S_WAKE1 = 5'd12;
  localparam logic [4:0] S_WALK0 = 5'd13;
  localparam logic [4:0] S_WALK1 = 5'd14;
  localparam logic [4:0] S_WALK2 = 5'd15;
  localparam logic [4:0] S_SC1   = 5'd16;
  localparam logic [4:0] S_SC2   = 5'd17;
  localparam logic [4:0] S_SC3   = 5'd18;
  localparam logic [4:0] S_DONE  = 5'd19;

  localparam logic [1:0] CTX_SCHED = 2'd0;
  localparam logic [1:0] CTX_DEFER = 2'd1;
  localparam logic [1:0] CTX_EXIT  = 2'd2;

  localparam slot_t LAST_SLOT = SLOT_W'(THREADS - 1);

  logic [4:0] state_r, state_nxt;
  logic [1:0] ctx_r, ctx_nxt;
  logic [2:0] mode_r, mode_nxt;
  logic       det_r, det_nxt;
  slot_t      tgt_r, tgt_nxt;
  slot_t      before_r, before_nxt;
  slot_t      cur_r, cur_nxt;
  slot_t      fhead_r, fhead_nxt;
  cnt_t       fcnt_r, fcnt_nxt;
  slot_t      t_r, t_nxt;
  slot_t      p_r, p_nxt;
  slot_t      nx_r, nx_nxt;
  slot_t      j_r, j_nxt;
  slot_t      start_r, start_nxt;
  slot_t      n_r, n_nxt;
  slot_t      init_r, init_nxt;
  flags_t     ft_r, ft_nxt;
  logic [2:0] status_r, status_nxt;
  slot_t      created_r, created_nxt;

  logic       out_valid_r;
  logic [2:0] out_status_r;
  slot_t      out_running_r;
  slot_t      out_created_r;
  logic       out_switched_r;

  logic   fl_we, nx_we, pv_we, jn_we;
  slot_t  fl_wa, nx_wa, pv_wa, jn_wa;
  flags_t fl_wd;
  slot_t  nx_wd, pv_wd, jn_wd;
  slot_t  fl_ra, nx_ra, pv_ra, jn_ra;
  flags_t fl_rd;
  slot_t  nx_rd, pv_rd, jn_rd;

  logic   in_acc, out_free, tgt_ok;

  rts_ram #(.WIDTH(FLAG_W), .DEPTH(THREADS)) u_flags (
    .clk(clk), .we(fl_we), .waddr(fl_wa), .wdata(fl_wd), .raddr(fl_ra), .rdata(fl_rd)
  );
  rts_ram #(.WIDTH(SLOT_W), .DEPTH(THREADS)) u_next (
    .clk(clk), .we(nx_we), .waddr(nx_wa), .wdata(nx_wd), .raddr(nx_ra), .rdata(nx_rd)
  );
  rts_ram #(.WIDTH(SLOT_W), .DEPTH(THREADS)) u_prev (
    .clk(clk), .we(pv_we), .waddr(pv_wa), .wdata(pv_wd), .raddr(pv_ra), .rdata(pv_rd)
  );
  rts_ram #(.WIDTH(SLOT_W), .DEPTH(THREADS)) u_joiner (
    .clk(clk), .we(jn_we), .waddr(jn_wa), .wdata(jn_wd), .raddr(jn_ra), .rdata(jn_rd)
  );

  assign in_stall     = (state_r != S_IDLE);
  assign in_acc       = in_valid && !in_stall;
  assign out_free     = !out_valid_r || !out_stall;
  assign tgt_ok       = (32'(tgt_r) < THREADS);
  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_running  = 4'(out_running_r);
  assign out_created  = 4'(out_created_r);
  assign out_switched = out_switched_r;

  always_comb begin
    state_nxt   = state_r;
    ctx_nxt     = ctx_r;
    mode_nxt    = mode_r;
    det_nxt     = det_r;
    tgt_nxt     = tgt_r;
    before_nxt  = before_r;
    cur_nxt     = cur_r;
    fhead_nxt   = fhead_r;
    fcnt_nxt    = fcnt_r;
    t_nxt       = t_r;
    p_nxt       = p_r;
    nx_nxt      = nx_r;
    j_nxt       = j_r;
    start_nxt   = start_r;
    n_nxt       = n_r;
    init_nxt    = init_r;
    ft_nxt      = ft_r;
    status_nxt  = status_r;
    created_nxt = created_r;
    fl_we = 1'b0; fl_wa = '0; fl_wd = '0; fl_ra = '0;
    nx_we = 1'b0; nx_wa = '0; nx_wd = '0; nx_ra = '0;
    pv_we = 1'b0; pv_wa = '0; pv_wd = '0; pv_ra = '0;
    jn_we = 1'b0; jn_wa = '0; jn_wd = '0; jn_ra = '0;

    case (state_r)
      S_INIT: begin
        // slot 0 active and alone in the ring, free chain runs downward
        fl_we = 1'b1;
        fl_wa = init_r;
        fl_wd = '0;
        if (init_r == '0) begin
          fl_wd[F_RUNNING]  = 1'b1;
          fl_wd[F_RUNNABLE] = 1'b1;
          fl_wd[F_DETACHED] = 1'b1;
        end else begin
          fl_wd[F_FREE] = 1'b1;
        end
        nx_we = 1'b1;
        nx_wa = init_r;
        nx_wd = (init_r >= SLOT_W'(2)) ? init_r - 1'b1 : '0;
        pv_we = 1'b1;
        pv_wa = init_r;
        pv_wd = '0;
        init_nxt = init_r + 1'b1;
        if (init_r == LAST_SLOT) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          mode_nxt    = in_mode;
          det_nxt     = in_detach;
          tgt_nxt     = SLOT_W'(in_target);
          before_nxt  = cur_r;
          status_nxt  = ST_OK;
          created_nxt = '0;
          state_nxt   = S_DISP;
        end
      end
      S_DISP: begin
        case (mode_r)
          OP_CREATE: begin
            if (fcnt_r == '0) begin
              status_nxt = ST_NOFREE;
              state_nxt  = S_DONE;
            end else begin
              t_nxt     = fhead_r;
              nx_ra     = fhead_r;
              pv_ra     = cur_r;
              state_nxt = S_CR1;
            end
          end
          OP_YIELD: begin
            start_nxt = cur_r;
            ctx_nxt   = CTX_SCHED;
            state_nxt = S_WALK0;
          end
          OP_EXIT: begin
            fl_ra     = cur_r;
            nx_ra     = cur_r;
            pv_ra     = cur_r;
            jn_ra     = cur_r;
            state_nxt = S_EX1;
          end
          OP_JOIN: begin
            fl_ra     = tgt_r;
            state_nxt = tgt_ok ? S_JN1 : S_DONE;
          end
          OP_WAKE: begin
            fl_ra     = tgt_r;
            state_nxt = tgt_ok ? S_WAKE1 : S_DONE;
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_CR1: begin
        p_nxt     = pv_rd;
        fhead_nxt = nx_rd;
        fcnt_nxt  = fcnt_r - 1'b1;
        fl_we = 1'b1;
        fl_wa = t_r;
        fl_wd = '0;
        fl_wd[F_RUNNABLE] = 1'b1;
        fl_wd[F_DETACHED] = det_r;
        pv_we = 1'b1; pv_wa = t_r;   pv_wd = pv_rd;
        nx_we = 1'b1; nx_wa = pv_rd; nx_wd = t_r;
        created_nxt = t_r;
        state_nxt   = S_CR2;
      end
      S_CR2: begin
        nx_we = 1'b1; nx_wa = t_r;   nx_wd = cur_r;
        pv_we = 1'b1; pv_wa = cur_r; pv_wd = t_r;
        state_nxt = S_DONE;
      end
      S_EX1: begin
        p_nxt  = pv_rd;
        nx_nxt = nx_rd;
        j_nxt  = jn_rd;
        if (!fl_rd[F_DETACHED] && !fl_rd[F_JOINED]) begin
          // joinable and not joined yet: acts as a yield
          start_nxt = cur_r;
          ctx_nxt   = CTX_DEFER;
          state_nxt = S_WALK0;
        end else if (pv_rd == cur_r) begin
          status_nxt = ST_LAST;
          state_nxt  = S_DONE;
        end else if (!fl_rd[F_DETACHED]) begin
          fl_ra     = jn_rd;
          state_nxt = S_EX2;
        end else begin
          state_nxt = S_EX3;
        end
      end
      S_EX2: begin
        if (!fl_rd[F_FREE]) begin
          fl_we = 1'b1;
          fl_wa = j_r;
          fl_wd = fl_rd;
          fl_wd[F_RUNNABLE] = 1'b1;
        end
        state_nxt = S_EX3;
      end
      S_EX3: begin
        fl_we = 1'b1;
        fl_wa = cur_r;
        fl_wd = '0;
        fl_wd[F_FREE] = 1'b1;
        nx_we = 1'b1; nx_wa = p_r;  nx_wd = nx_r;
        pv_we = 1'b1; pv_wa = nx_r; pv_wd = p_r;
        state_nxt = S_EX4;
      end
      S_EX4: begin
        nx_we = 1'b1; nx_wa = cur_r; nx_wd = fhead_r;
        fhead_nxt = cur_r;
        if (fcnt_r < CNT_W'(THREADS - 1)) begin
          fcnt_nxt = fcnt_r + 1'b1;
        end
        cur_nxt   = p_r;
        start_nxt = p_r;
        ctx_nxt   = CTX_EXIT;
        state_nxt = S_WALK0;
      end
      S_JN1: begin
        if (fl_rd[F_FREE]) begin
          state_nxt = S_DONE;
        end else if (fl_rd[F_DETACHED]) begin
          status_nxt = ST_JOINDET;
          state_nxt  = S_DONE;
        end else begin
          jn_we = 1'b1; jn_wa = tgt_r; jn_wd = cur_r;
          fl_we = 1'b1;
          fl_wa = tgt_r;
          fl_wd = fl_rd;
          fl_wd[F_JOINED] = 1'b1;
          state_nxt = S_JN2;
        end
      end
      S_JN2: begin
        // read after the write above, target may be the current slot
        fl_ra     = cur_r;
        state_nxt = S_JN3;
      end
      S_JN3: begin
        fl_we = 1'b1;
        fl_wa = cur_r;
        fl_wd = fl_rd;
        fl_wd[F_RUNNING]  = 1'b0;
        fl_wd[F_RUNNABLE] = 1'b0;
        start_nxt = cur_r;
        ctx_nxt   = CTX_SCHED;
        state_nxt = S_WALK0;
      end
      S_WAKE1: begin
        if (!fl_rd[F_FREE]) begin
          fl_we = 1'b1;
          fl_wa = tgt_r;
          fl_wd = fl_rd;
          fl_wd[F_RUNNABLE] = 1'b1;
        end
        state_nxt = S_DONE;
      end
      S_WALK0: begin
        nx_ra     = start_r;
        state_nxt = S_WALK1;
      end
      S_WALK1: begin
        t_nxt     = nx_rd;
        fl_ra     = nx_rd;
        nx_ra     = nx_rd;
        n_nxt     = '0;
        state_nxt = S_WALK2;
      end
      S_WALK2: begin
        if (fl_rd[F_RUNNABLE]) begin
          ft_nxt    = fl_rd;
          state_nxt = (ctx_r == CTX_EXIT) ? S_SC3 : S_SC1;
        end else if (t_r == start_r || n_r == LAST_SLOT) begin
          status_nxt = ST_IDLE;
          state_nxt  = S_DONE;
        end else begin
          t_nxt = nx_rd;
          fl_ra = nx_rd;
          nx_ra = nx_rd;
          n_nxt = n_r + 1'b1;
        end
      end
      S_SC1: begin
        fl_ra     = cur_r;
        state_nxt = S_SC2;
      end
      S_SC2: begin
        if (t_r != cur_r) begin
          fl_we = 1'b1;
          fl_wa = cur_r;
          fl_wd = fl_rd;
          fl_wd[F_RUNNING] = 1'b0;
        end
        state_nxt = S_SC3;
      end
      S_SC3: begin
        fl_we = 1'b1;
        fl_wa = t_r;
        fl_wd = ft_r;
        fl_wd[F_RUNNING] = 1'b1;
        cur_nxt    = t_r;
        status_nxt = (ctx_r == CTX_DEFER) ? ST_DEFER : ST_OK;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      init_r      <= '0;
      cur_r       <= '0;
      fhead_r     <= LAST_SLOT;
      fcnt_r      <= CNT_W'(THREADS - 1);
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      init_r  <= init_nxt;
      cur_r   <= cur_nxt;
      fhead_r <= fhead_nxt;
      fcnt_r  <= fcnt_nxt;
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ctx_r     <= ctx_nxt;
    mode_r    <= mode_nxt;
    det_r     <= det_nxt;
    tgt_r     <= tgt_nxt;
    before_r  <= before_nxt;
    t_r       <= t_nxt;
    p_r       <= p_nxt;
    nx_r      <= nx_nxt;
    j_r       <= j_nxt;
    start_r   <= start_nxt;
    n_r       <= n_nxt;
    ft_r      <= ft_nxt;
    status_r  <= status_nxt;
    created_r <= created_nxt;
    if (state_r == S_DONE && out_free) begin
      out_status_r   <= status_r;
      out_running_r  <= cur_r;
      out_created_r  <= created_r;
      out_switched_r <= (cur_r != before_r);
    end
  end

endmodule
